// File: design/kpg_pkg.sv
// Shared constants and types of the keyed permutation generator.
// No dependencies; every other design file but kpg_ram refers to it by scoped names.
`default_nettype none

package kpg_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned DIV_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [63:0] DEFAULT_SEED = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] GEN_MUL = 64'd6364136223846793005;
  localparam logic [63:0] GEN_ADD = 64'd1442695040888963407;
  localparam int unsigned SH1 = 17;
  localparam int unsigned SH2 = 31;
  localparam int unsigned SH3 = 8;

  localparam int unsigned DIV_BITS = 4;
  localparam int unsigned DIV_STEPS = 64 / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic        valid;
    logic [63:0] seed;
  } kpg_seed_t;

  typedef struct packed {
    logic             load;
    logic [63:0]      seed;
    logic             start;
    logic [DIV_W-1:0] divisor;
  } kpg_gen_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } kpg_gen_rsp_t;

endpackage

`default_nettype wire

// File: design/kpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kpg_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/kpg_front.sv
// Front end: accepts keys, substitutes the default seed for a zero key and
// queues seeds for the back end. Depends on kpg_pkg.
`default_nettype none

module kpg_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [63:0]       seed_key_i,
  output kpg_pkg::kpg_seed_t     q_o,
  input  wire logic              pop_i
);

  localparam int unsigned PTR_W = $clog2(kpg_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(kpg_pkg::FIFO_DEPTH + 1);

  logic [63:0]      entry_q [kpg_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;
  logic [63:0]      seed;

  assign in_stall_o = (count_q == CNT_W'(kpg_pkg::FIFO_DEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign pop = pop_i && (count_q != '0);
  assign seed = (seed_key_i == 64'd0) ? kpg_pkg::DEFAULT_SEED : seed_key_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(kpg_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(kpg_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= seed;
    end
  end

  assign q_o.valid = (count_q != '0);
  assign q_o.seed = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: design/kpg_gen.sv
// Generator step unit: 64-bit multiply-add on one shared 32x32 multiplier,
// xorshift mix, then an iterative remainder by the swap range. Depends on kpg_pkg.
`default_nettype none

module kpg_gen (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kpg_pkg::kpg_gen_req_t req_i,
  output kpg_pkg::kpg_gen_rsp_t  rsp_o
);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_M0   = 3'd1;
  localparam logic [2:0] G_M1   = 3'd2;
  localparam logic [2:0] G_M2   = 3'd3;
  localparam logic [2:0] G_MIX  = 3'd4;
  localparam logic [2:0] G_DIV  = 3'd5;

  localparam int unsigned IW = kpg_pkg::IDX_W;
  localparam int unsigned DW = kpg_pkg::DIV_W;

  logic [2:0]                    state_q, state_d;
  logic [kpg_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [63:0]                   gen_q;
  logic [63:0]                   acc_q;
  logic [63:0]                   dvd_q;
  logic [IW-1:0]                 rem_q;
  logic [DW-1:0]                 div_q;
  logic [31:0]                   mul_a;
  logic [31:0]                   mul_b;
  logic [63:0]                   prod;
  logic [63:0]                   sum;
  logic [63:0]                   mix1;
  logic [63:0]                   mix2;
  logic [63:0]                   mix3;
  logic [DW-1:0]                 r_tmp;
  logic [63:0]                   d_tmp;
  logic [IW-1:0]                 rem_next;
  logic [63:0]                   dvd_next;

  always_comb begin
    case (state_q)
      G_M0: begin
        mul_a = gen_q[31:0];
        mul_b = kpg_pkg::GEN_MUL[31:0];
      end
      G_M1: begin
        mul_a = gen_q[63:32];
        mul_b = kpg_pkg::GEN_MUL[31:0];
      end
      default: begin
        mul_a = gen_q[31:0];
        mul_b = kpg_pkg::GEN_MUL[63:32];
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum = acc_q + kpg_pkg::GEN_ADD;
  assign mix1 = sum ^ (sum >> kpg_pkg::SH1);
  assign mix2 = mix1 ^ (mix1 << kpg_pkg::SH2);
  assign mix3 = mix2 ^ (mix2 >> kpg_pkg::SH3);

  always_comb begin
    r_tmp = {1'b0, rem_q};
    d_tmp = dvd_q;
    for (int k = 0; k < kpg_pkg::DIV_BITS; k++) begin
      r_tmp = {r_tmp[IW-1:0], d_tmp[63]};
      d_tmp = {d_tmp[62:0], 1'b0};
      if (r_tmp >= div_q) begin
        r_tmp = r_tmp - div_q;
      end
    end
    rem_next = r_tmp[IW-1:0];
    dvd_next = d_tmp;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    case (state_q)
      G_IDLE: begin
        if (req_i.start) begin
          state_d = G_M0;
        end
      end
      G_M0:  state_d = G_M1;
      G_M1:  state_d = G_M2;
      G_M2:  state_d = G_MIX;
      G_MIX: begin
        state_d = G_DIV;
        cnt_d = '0;
      end
      G_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == kpg_pkg::DIV_CNT_W'(kpg_pkg::DIV_STEPS - 1)) begin
          state_d = G_IDLE;
          done_d = 1'b1;
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
      gen_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
      if (req_i.load) begin
        gen_q <= req_i.seed;
      end else if (state_q == G_MIX) begin
        gen_q <= mix3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      G_IDLE: begin
        div_q <= req_i.divisor;
      end
      G_M0: begin
        acc_q <= prod;
      end
      G_M1, G_M2: begin
        acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      end
      G_MIX: begin
        dvd_q <= mix3;
        rem_q <= '0;
      end
      G_DIV: begin
        dvd_q <= dvd_next;
        rem_q <= rem_next;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem = rem_q;

endmodule

`default_nettype wire

// File: design/kpg_back.sv
// Back end: identity fill, Fisher-Yates swaps, inverse build and result
// emission. Depends on kpg_pkg, kpg_gen and kpg_ram.
`default_nettype none

module kpg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kpg_pkg::kpg_seed_t            q_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [kpg_pkg::IDX_W-1:0]     slot_o,
  output logic      [kpg_pkg::IDX_W-1:0]     mapped_o,
  output logic      [kpg_pkg::IDX_W-1:0]     inverse_o,
  output logic                               last_o
);

  localparam int unsigned IW = kpg_pkg::IDX_W;

  localparam logic [3:0] B_IDLE   = 4'd0;
  localparam logic [3:0] B_INIT   = 4'd1;
  localparam logic [3:0] B_GEN    = 4'd2;
  localparam logic [3:0] B_GWAIT  = 4'd3;
  localparam logic [3:0] B_RDI    = 4'd4;
  localparam logic [3:0] B_RDJ    = 4'd5;
  localparam logic [3:0] B_WRI    = 4'd6;
  localparam logic [3:0] B_WRJ    = 4'd7;
  localparam logic [3:0] B_INV_RD = 4'd8;
  localparam logic [3:0] B_INV_WR = 4'd9;
  localparam logic [3:0] B_EM_RD  = 4'd10;
  localparam logic [3:0] B_EM_LD  = 4'd11;

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] di_q;
  logic          out_valid_q, out_valid_d;
  logic [IW-1:0] slot_q;
  logic [IW-1:0] mapped_q;
  logic [IW-1:0] inverse_q;
  logic          last_q;
  logic          out_free;
  logic          load_out;

  kpg_pkg::kpg_gen_req_t gen_req;
  kpg_pkg::kpg_gen_rsp_t gen_rsp;

  logic          fwd_we;
  logic [IW-1:0] fwd_waddr;
  logic [IW-1:0] fwd_wdata;
  logic [IW-1:0] fwd_raddr;
  logic [IW-1:0] fwd_rdata;
  logic          inv_we;
  logic [IW-1:0] inv_rdata;

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == B_EM_LD);
  assign pop_o = (state_q == B_IDLE) && q_i.valid;

  assign gen_req.load = pop_o;
  assign gen_req.seed = q_i.seed;
  assign gen_req.start = (state_q == B_GEN);
  assign gen_req.divisor = {1'b0, i_q} + kpg_pkg::DIV_W'(1);

  kpg_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gen_req),
    .rsp_o  (gen_rsp)
  );

  always_comb begin
    fwd_we = (state_q == B_INIT) || (state_q == B_WRI) || (state_q == B_WRJ);
    case (state_q)
      B_INIT: begin
        fwd_waddr = k_q;
        fwd_wdata = k_q;
      end
      B_WRI: begin
        fwd_waddr = i_q;
        fwd_wdata = fwd_rdata;
      end
      default: begin
        fwd_waddr = j_q;
        fwd_wdata = di_q;
      end
    endcase
    case (state_q)
      B_RDJ:             fwd_raddr = j_q;
      B_INV_RD, B_EM_RD: fwd_raddr = k_q;
      default:           fwd_raddr = i_q;
    endcase
  end

  assign inv_we = (state_q == B_INV_WR);

  kpg_ram #(
    .WIDTH (kpg_pkg::IDX_W),
    .DEPTH (kpg_pkg::DEPTH)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .raddr_i (fwd_raddr),
    .rdata_o (fwd_rdata)
  );

  kpg_ram #(
    .WIDTH (kpg_pkg::IDX_W),
    .DEPTH (kpg_pkg::DEPTH)
  ) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (fwd_rdata),
    .wdata_i (k_q),
    .raddr_i (k_q),
    .rdata_o (inv_rdata)
  );

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    i_d = i_q;
    j_d = j_q;
    case (state_q)
      B_IDLE: begin
        if (q_i.valid) begin
          state_d = B_INIT;
          k_d = '0;
        end
      end
      B_INIT: begin
        k_d = k_q + 1'b1;
        if (k_q == kpg_pkg::LAST_IDX) begin
          state_d = B_GEN;
          i_d = kpg_pkg::LAST_IDX;
        end
      end
      B_GEN:   state_d = B_GWAIT;
      B_GWAIT: begin
        if (gen_rsp.done) begin
          state_d = B_RDI;
          j_d = gen_rsp.rem;
        end
      end
      B_RDI:   state_d = B_RDJ;
      B_RDJ:   state_d = B_WRI;
      B_WRI:   state_d = B_WRJ;
      B_WRJ: begin
        if (i_q == IW'(1)) begin
          state_d = B_INV_RD;
          k_d = '0;
        end else begin
          state_d = B_GEN;
          i_d = i_q - 1'b1;
        end
      end
      B_INV_RD: state_d = B_INV_WR;
      B_INV_WR: begin
        k_d = k_q + 1'b1;
        if (k_q == kpg_pkg::LAST_IDX) begin
          state_d = B_EM_RD;
          k_d = '0;
        end else begin
          state_d = B_INV_RD;
        end
      end
      B_EM_RD: begin
        if (out_free) begin
          state_d = B_EM_LD;
        end
      end
      B_EM_LD: begin
        k_d = k_q + 1'b1;
        state_d = (k_q == kpg_pkg::LAST_IDX) ? B_IDLE : B_EM_RD;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      i_q <= i_d;
      j_q <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_RDJ) begin
      di_q <= fwd_rdata;
    end
    if (load_out) begin
      slot_q <= k_q;
      mapped_q <= fwd_rdata;
      inverse_q <= inv_rdata;
      last_q <= (k_q == kpg_pkg::LAST_IDX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign slot_o = slot_q;
  assign mapped_o = mapped_q;
  assign inverse_o = inverse_q;
  assign last_o = last_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_rsp.done |-> (state_q == B_GWAIT))
    else $error("generator result arrived outside the wait state");

  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_rsp.done && (state_q == B_GWAIT)) |-> ({1'b0, gen_rsp.rem} < gen_req.divisor))
    else $error("swap partner beyond current index");

  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_valid_q)
    else $error("output register overwritten");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q == (slot_q == kpg_pkg::LAST_IDX)))
    else $error("last flag does not match slot");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == B_INIT))
    else $error("seed popped without starting a run");

endmodule

`default_nettype wire

// File: design/keyed_permutation_generator_unit.sv
// Top level of the keyed permutation generator: front end, seed queue and back end.
// Depends on kpg_pkg, kpg_front and kpg_back.
//
// Usage: the input channel takes one 64-bit key per transaction (in_valid_i,
// in_stall_o, seed_key_i); a zero key selects the built-in default seed. For
// every key the output channel delivers ENTRIES transactions (out_valid_o,
// out_stall_i) with slot ascending from zero, the permuted entry, the inverse
// entry and last set on the final slot.
// Sequence per key: an identity fill of the forward table, then ENTRIES-1 swaps,
// each set by the generator step (three passes of one shared 32x32
// multiplier, one mix step, and a remainder unit taking four bits a cycle)
// plus two reads and two writes through the one read port and the
// one write port of the forward table.
// The inverse table build and the emission then each handle one slot at a
// time, in ascending slot order.
// Up to two further keys wait in the front queue while a run is in progress.
// Reset clears the queue, the sequencer and the output valid; the tables need
// no clearing since each run rewrites them before reading.
// A stall on the output holds the current result; the run pauses at the next
// slot until it is taken, and the front queue keeps accepting keys until full.
`default_nettype none

module keyed_permutation_generator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [63:0]                seed_key_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [kpg_pkg::IDX_W-1:0]  slot_o,
  output logic      [kpg_pkg::IDX_W-1:0]  mapped_o,
  output logic      [kpg_pkg::IDX_W-1:0]  inverse_o,
  output logic                            last_o
);

  kpg_pkg::kpg_seed_t seed_q;
  logic               pop;

  kpg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .seed_key_i (seed_key_i),
    .q_o        (seed_q),
    .pop_i      (pop)
  );

  kpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (seed_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .slot_o      (slot_o),
    .mapped_o    (mapped_o),
    .inverse_o   (inverse_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/kpg_checker.sv
// Checker for the keyed permutation generator: watches both channels, predicts the
// permutation and inverse of every accepted key and compares each emitted slot.
// Depends on kpg_pkg for widths and generator constants.
module kpg_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [63:0]               seed_key_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [kpg_pkg::IDX_W-1:0] slot_i,
  input  logic [kpg_pkg::IDX_W-1:0] mapped_i,
  input  logic [kpg_pkg::IDX_W-1:0] inverse_i,
  input  logic                      last_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [kpg_pkg::IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t slot;
    idx_t mapped;
    idx_t inverse;
    logic last;
  } slot_result_t;

  slot_result_t expected_slots_q[$];

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  function automatic logic [63:0] mix_step(input logic [63:0] s);
    logic [63:0] t;
    t = s * kpg_pkg::GEN_MUL + kpg_pkg::GEN_ADD;
    t = t ^ (t >> kpg_pkg::SH1);
    t = t ^ (t << kpg_pkg::SH2);
    t = t ^ (t >> kpg_pkg::SH3);
    return t;
  endfunction

  function automatic void predict_permutation(input logic [63:0] key);
    idx_t         fwd [kpg_pkg::ENTRIES];
    idx_t         inv [kpg_pkg::ENTRIES];
    idx_t         held;
    logic [63:0]  state;
    int           j;
    slot_result_t res;
    for (int i = 0; i < kpg_pkg::ENTRIES; i++) fwd[i] = idx_t'(i);
    state = (key == 64'd0) ? kpg_pkg::DEFAULT_SEED : key;
    for (int i = kpg_pkg::ENTRIES - 1; i > 0; i--) begin
      state = mix_step(state);
      j = int'(state % 64'(i + 1));
      held = fwd[i];
      fwd[i] = fwd[j];
      fwd[j] = held;
    end
    for (int i = 0; i < kpg_pkg::ENTRIES; i++) inv[fwd[i]] = idx_t'(i);
    for (int i = 0; i < kpg_pkg::ENTRIES; i++) begin
      res.slot = idx_t'(i);
      res.mapped = fwd[i];
      res.inverse = inv[i];
      res.last = (i == kpg_pkg::ENTRIES - 1);
      expected_slots_q.push_back(res);
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    if (!rst_ni) begin
      expected_slots_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_permutation(seed_key_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_slots_q.size() == 0) begin
          $display({"%0t: unexpected transaction: expected none, ",
                    "actual slot %0d mapped %0d inverse %0d last %0b"},
                   $time, slot_i, mapped_i, inverse_i, last_i);
          fail_count_o++;
        end else begin
          want = expected_slots_q.pop_front();
          check_field("slot", want.slot, slot_i);
          check_field("mapped", want.mapped, mapped_i);
          check_field("inverse", want.inverse, inverse_i);
          check_field("last", want.last, last_i);
        end
      end
    end
    pending_o = expected_slots_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for keyed_permutation_generator_unit: drives keys in bursts, stalls
// the result channel on its own pattern and gives the verdict from kpg_checker.
// Depends on kpg_pkg, the block and kpg_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 6000;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 2500;
  localparam int RANDOM_KEYS = 126;
  localparam int DIRECTED_COUNT = 14;
  localparam logic [63:0] DIRECTED_KEYS [DIRECTED_COUNT] = '{
    64'h0000000000000000, 64'h0000000000000001, 64'hFFFFFFFFFFFFFFFF,
    64'h8000000000000000, kpg_pkg::DEFAULT_SEED, 64'h5555555555555555,
    64'hAAAAAAAAAAAAAAAA, 64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000,
    64'h0000000000000002, 64'h0123456789ABCDEF, 64'h0000000000000000,
    64'h0000000000000000, 64'h0000000000000040
  };

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [63:0]               seed_key = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [kpg_pkg::IDX_W-1:0] slot;
  logic [kpg_pkg::IDX_W-1:0] mapped;
  logic [kpg_pkg::IDX_W-1:0] inverse;
  logic                      last_flag;
  int                        fail_count;
  int                        pending;
  int                        keys_sent = 0;
  int                        burst_left = 1;
  int                        idle_cycles = 0;
  bit                        held_off = 1'b0;

  keyed_permutation_generator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .seed_key_i  (seed_key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .slot_o      (slot),
    .mapped_o    (mapped),
    .inverse_o   (inverse),
    .last_o      (last_flag)
  );

  kpg_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .seed_key_i   (seed_key),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .slot_i       (slot),
    .mapped_i     (mapped),
    .inverse_i    (inverse),
    .last_i       (last_flag),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] random_key();
    logic [63:0] k;
    case ($urandom_range(0, 9))
      0: k = 64'($urandom_range(0, 255));
      1: k = 64'd1 << $urandom_range(0, 63);
      2: k = ~(64'd1 << $urandom_range(0, 63));
      3: k = 64'd0;
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  task automatic send_key(input logic [63:0] key);
    int gap;
    in_valid <= 1'b1;
    seed_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    keys_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Receiver: segments of random stall modes, plus one long hold-off.
  initial begin
    int seg;
    int mode;
    forever begin
      seg = $urandom_range(16, 400);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (!held_off && keys_sent >= 3) begin
          held_off = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 8);
    foreach (DIRECTED_KEYS[i]) send_key(DIRECTED_KEYS[i]);
    repeat (RANDOM_KEYS) send_key(random_key());
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
